FILE: hw/rtl/oal_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array list engine package
// Shared sizes, operation and status codes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oal_pkg;

	// List capacity and the widths that follow from it.
	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Fixed payload widths.
	localparam int VALUE_W  = 32;
	localparam int FIDX_W   = 7;
	localparam int OCNT_W   = 8;

	// Match search is split into groups, encoded one level per cycle.
	localparam int GRP      = (CAPACITY < 16) ? CAPACITY : 16;
	localparam int GRP_W    = $clog2(GRP);
	localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

	typedef enum logic [1:0] {
		OP_FIND   = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} oal_op_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_BADPOS   = 2'd2,
		STATUS_NOTFOUND = 2'd3
	} oal_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GROUP,
		ST_RESOLVE,
		ST_DONE
	} oal_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic exec;
		logic group;
		logic resolve;
		logic load_out;
	} oal_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_find;
	} oal_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/oal_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one list operation per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface oal_req_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          opcode;
	logic signed [oal_pkg::VALUE_W-1:0]  value;
	logic [oal_pkg::POS_W-1:0]           position;

	modport source (output valid, opcode, value, position, input ready);
	modport sink   (input valid, opcode, value, position, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/oal_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item per operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface oal_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [oal_pkg::FIDX_W-1:0]   found_index;
	logic [oal_pkg::OCNT_W-1:0]   count;

	modport source (output valid, status, found_index, count, input ready);
	modport sink   (input valid, status, found_index, count, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/oal_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered array list controller
// State machine that sequences each operation through the datapath and
// owns the request ready and the response valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oal_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output oal_pkg::oal_cmd_t      cmd,
	input  wire oal_pkg::oal_sts_t sts
);

	oal_pkg::oal_state_t state_q;
	oal_pkg::oal_state_t state_d;
	logic                out_valid_q;
	logic                out_free;

	// The output register can take a new result when empty or draining.
	assign out_free = !out_valid_q || rsp_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oal_pkg::ST_IDLE: begin
				if (req_valid) state_d = oal_pkg::ST_EXEC;
			end
			oal_pkg::ST_EXEC: begin
				state_d = sts.is_find ? oal_pkg::ST_GROUP : oal_pkg::ST_DONE;
			end
			oal_pkg::ST_GROUP: begin
				state_d = oal_pkg::ST_RESOLVE;
			end
			oal_pkg::ST_RESOLVE: begin
				state_d = oal_pkg::ST_DONE;
			end
			oal_pkg::ST_DONE: begin
				if (out_free) state_d = oal_pkg::ST_IDLE;
			end
			default: begin
				state_d = oal_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		req_ready    = 1'b0;
		cmd          = '0;
		unique case (state_q)
			oal_pkg::ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.load_in = req_valid;
			end
			oal_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			oal_pkg::ST_GROUP: begin
				cmd.group = 1'b1;
			end
			oal_pkg::ST_RESOLVE: begin
				cmd.resolve = 1'b1;
			end
			oal_pkg::ST_DONE: begin
				cmd.load_out = out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

	// State register and response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oal_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/oal_dp.sv
// ----------------------------------------------------------------------------
// Ordered array list datapath
// Row of list cells that shift up or down all at once, the fill count,
// a parallel match stage with a two-level registered priority encoder,
// and the result and output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oal_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire oal_pkg::oal_cmd_t                    cmd,
	output oal_pkg::oal_sts_t                         sts,
	input  wire logic [1:0]                           opcode,
	input  wire logic signed [oal_pkg::VALUE_W-1:0]   value,
	input  wire logic [oal_pkg::POS_W-1:0]            position,
	output logic [1:0]                                status,
	output logic [oal_pkg::FIDX_W-1:0]                found_index,
	output logic [oal_pkg::OCNT_W-1:0]                count
);

	oal_pkg::oal_op_t                op_q;
	logic [oal_pkg::VALUE_W-1:0]     val_q;
	logic [oal_pkg::POS_W-1:0]       pos_q;
	logic [oal_pkg::CNT_W-1:0]       count_q;

	logic [oal_pkg::VALUE_W-1:0]     cells_q [oal_pkg::CAPACITY];
	logic [oal_pkg::CAPACITY-1:0]    match_s1;
	logic [oal_pkg::NGRP-1:0]        grp_any_s2;
	logic [oal_pkg::GRP_W-1:0]       grp_idx_s2 [oal_pkg::NGRP];

	logic [oal_pkg::NGRP-1:0]        grp_any_d;
	logic [oal_pkg::GRP_W-1:0]       grp_idx_d [oal_pkg::NGRP];
	logic                            any_d;
	logic [oal_pkg::IDX_W-1:0]       idx_d;

	oal_pkg::oal_status_t            res_status_q;
	logic [oal_pkg::IDX_W-1:0]       res_index_q;
	logic [oal_pkg::CNT_W-1:0]       res_count_q;
	oal_pkg::oal_status_t            out_status_q;
	logic [oal_pkg::FIDX_W-1:0]      out_index_q;
	logic [oal_pkg::OCNT_W-1:0]      out_count_q;

	logic [oal_pkg::CMP_W-1:0]       pos_ext;
	logic [oal_pkg::CMP_W-1:0]       cnt_ext;
	logic                            is_full;
	logic                            ins_ok;
	logic                            del_ok;
	logic                            do_ins;
	logic                            do_del;

	assign sts.is_find = (op_q == oal_pkg::OP_FIND);

	// Operation checks against the current fill count.
	assign pos_ext = oal_pkg::CMP_W'(pos_q);
	assign cnt_ext = oal_pkg::CMP_W'(count_q);
	assign is_full = (count_q == oal_pkg::CNT_W'(oal_pkg::CAPACITY));
	assign ins_ok  = !is_full && (pos_ext <= cnt_ext);
	assign del_ok  = (pos_ext < cnt_ext);
	assign do_ins  = cmd.exec && (op_q == oal_pkg::OP_INSERT) && ins_ok;
	assign do_del  = cmd.exec && (op_q == oal_pkg::OP_DELETE) && del_ok;

	// Capture the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= oal_pkg::oal_op_t'(opcode);
			val_q <= value;
			pos_q <= position;
		end
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == oal_pkg::OP_CLEAR) begin
				count_q <= '0;
			end else if (do_ins) begin
				count_q <= count_q + 1'b1;
			end else if (do_del) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Cell row: each cell loads from its lower neighbour, its upper
	// neighbour or the new value, and compares itself against the key.
	for (genvar i = 0; i < oal_pkg::CAPACITY; i++) begin : g_cell
		logic [oal_pkg::VALUE_W-1:0] lower;
		logic [oal_pkg::VALUE_W-1:0] upper;
		logic [oal_pkg::CMP_W-1:0]   here;

		assign here = oal_pkg::CMP_W'(i);
		if (i == 0) begin : g_first
			assign lower = val_q;
		end else begin : g_mid_lo
			assign lower = cells_q[i-1];
		end
		if (i == oal_pkg::CAPACITY - 1) begin : g_last
			assign upper = cells_q[i];
		end else begin : g_mid_hi
			assign upper = cells_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (do_ins) begin
				if (here > pos_ext) begin
					cells_q[i] <= lower;
				end else if (here == pos_ext) begin
					cells_q[i] <= val_q;
				end
			end else if (do_del && (here >= pos_ext)) begin
				cells_q[i] <= upper;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				match_s1[i] <= (cells_q[i] == val_q) && (here < cnt_ext);
			end
		end
	end

	// First level of the search: lowest match inside each group.
	always_comb begin
		for (int g = 0; g < oal_pkg::NGRP; g++) begin
			grp_any_d[g] = 1'b0;
			grp_idx_d[g] = '0;
			for (int j = oal_pkg::GRP - 1; j >= 0; j--) begin
				if ((g * oal_pkg::GRP + j) < oal_pkg::CAPACITY) begin
					if (match_s1[g * oal_pkg::GRP + j]) begin
						grp_any_d[g] = 1'b1;
						grp_idx_d[g] = oal_pkg::GRP_W'(j);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.group) begin
			grp_any_s2 <= grp_any_d;
			grp_idx_s2 <= grp_idx_d;
		end
	end

	// Second level of the search: lowest group with a match.
	always_comb begin
		any_d = 1'b0;
		idx_d = '0;
		for (int g = oal_pkg::NGRP - 1; g >= 0; g--) begin
			if (grp_any_s2[g]) begin
				any_d = 1'b1;
				idx_d = oal_pkg::IDX_W'(g * oal_pkg::GRP) + oal_pkg::IDX_W'(grp_idx_s2[g]);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_index_q <= '0;
			res_count_q <= count_q;
			unique case (op_q)
				oal_pkg::OP_INSERT: begin
					if (is_full) begin
						res_status_q <= oal_pkg::STATUS_FULL;
					end else if (!ins_ok) begin
						res_status_q <= oal_pkg::STATUS_BADPOS;
					end else begin
						res_status_q <= oal_pkg::STATUS_OK;
						res_count_q  <= count_q + 1'b1;
					end
				end
				oal_pkg::OP_DELETE: begin
					if (!del_ok) begin
						res_status_q <= oal_pkg::STATUS_BADPOS;
					end else begin
						res_status_q <= oal_pkg::STATUS_OK;
						res_count_q  <= count_q - 1'b1;
					end
				end
				oal_pkg::OP_CLEAR: begin
					res_status_q <= oal_pkg::STATUS_OK;
					res_count_q  <= '0;
				end
				default: begin
					res_status_q <= oal_pkg::STATUS_NOTFOUND;
				end
			endcase
		end else if (cmd.resolve) begin
			res_status_q <= any_d ? oal_pkg::STATUS_OK : oal_pkg::STATUS_NOTFOUND;
			res_index_q  <= any_d ? idx_d : '0;
		end
	end

	// Output register, held while the receiver stalls.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_index_q  <= oal_pkg::FIDX_W'(res_index_q);
			out_count_q  <= oal_pkg::OCNT_W'(res_count_q);
		end
	end

	assign status      = out_status_q;
	assign found_index = out_index_q;
	assign count       = out_count_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_array_list_engine_core.sv
// ----------------------------------------------------------------------------
// Ordered array list engine
// Positional list of 32-bit values with find, insert, delete and clear.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel takes one item per operation (opcode, value, position);
//   the rsp channel returns exactly one item per request (status,
//   found_index, count), in request order.
//   Insert, delete and clear go from acceptance through the execute state to
//   the output register; find also passes through the group and resolve
//   states, for the parallel compare across all cells followed by a
//   two-level registered priority encoder. Shifts for insert and delete
//   move the whole cell row at once. One item is worked on at a time: a new
//   request is accepted in the cycle after the previous one is handed to
//   the output register.
//   The output register holds a finished result while the receiver stalls,
//   and the next request is accepted and worked on meanwhile; it then waits
//   for the output register to free up.
//   Reset empties the list (fill count zero), returns the controller to idle
//   and drops the response valid; cell contents are left as they were and
//   are never read unless written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list_engine_core (
	input  wire logic  clk,
	input  wire logic  arst_n,
	oal_req_if.sink    req,
	oal_rsp_if.source  rsp
);

	oal_pkg::oal_cmd_t cmd;
	oal_pkg::oal_sts_t sts;

	// Sequencing.
	oal_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// List storage and search.
	oal_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (req.opcode),
		.value       (req.value),
		.position    (req.position),
		.status      (rsp.status),
		.found_index (rsp.found_index),
		.count       (rsp.count)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/oal_checker.sv
// ----------------------------------------------------------------------------
// Ordered array list checker
// Port-level assertions for the list engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oal_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_ready,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_ready,
	input wire logic [1:0]                   rsp_status,
	input wire logic [oal_pkg::FIDX_W-1:0]   rsp_found_index,
	input wire logic [oal_pkg::OCNT_W-1:0]   rsp_count
);

	// A stalled result item holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_found_index) && $stable(rsp_count))
		else $error("rsp item changed while stalled");

	// Only one item is in the engine at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// A full report means the list is at capacity.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == oal_pkg::STATUS_FULL)
			|-> rsp_count == oal_pkg::OCNT_W'(oal_pkg::CAPACITY))
		else $error("full status with list below capacity");

	// Any failing status carries a zero index.
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != oal_pkg::STATUS_OK) |-> rsp_found_index == '0)
		else $error("nonzero index on a failed operation");

	// A successful find points inside the list.
	a_found_inside: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == oal_pkg::STATUS_OK) && (rsp_found_index != '0)
			|-> oal_pkg::OCNT_W'(rsp_found_index) < rsp_count)
		else $error("found index beyond the fill count");

endmodule

bind ordered_array_list_engine_core oal_checker u_oal_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_found_index (rsp.found_index),
	.rsp_count       (rsp.count)
);

`default_nettype wire
